// ===== rtl/rotated_rect_bounding_box_defines.svh =====
// Assertion macros shared by the rotated-rectangle bounding box RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef ROTATED_RECT_BOUNDING_BOX_DEFINES_SVH
`define ROTATED_RECT_BOUNDING_BOX_DEFINES_SVH

// implication checked at every rising clock edge outside reset
`define RRBB_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// invariant checked at every rising clock edge outside reset
`define RRBB_ASSERT_ALW(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error(msg);

`endif

// ===== rtl/rrbb_pkg.sv =====
// Shared types, constants and the CORDIC arctangent table for the
// rotated-rectangle bounding box. No dependencies.
package rrbb_pkg;

	localparam int DIM_BITS_DEF  = 13;
	localparam int TRIG_ITER_DEF = 16;

	localparam int IN_W   = 13;   // width / height port width
	localparam int ANG_W  = 16;   // angle, Q3.13
	localparam int ANG_SH = 16;   // Q3.13 -> Q.29
	localparam int OUT_W  = 15;
	localparam int TRIG_W = 16;   // Q1.15 sine / cosine
	localparam int XY_W   = 34;   // CORDIC x / y, Q2.30 with headroom
	localparam int Z_W    = 33;   // CORDIC residual angle, Q.29

	localparam int GAIN_Q30    = 652032874;
	localparam int PI_Q29      = 1686629713;
	localparam int HALF_PI_Q29 = 843314857;
	localparam int RND_SH      = 15;      // Q2.30 -> Q1.15
	localparam int RND_HALF    = 16384;
	localparam int CENTER_SH   = 15;      // w * 2^15 is the centre times 2^16
	localparam int TRUNC_SH    = 16;
	localparam int TRUNC_BIAS  = 65535;

	// pipeline depth outside the CORDIC iterations
	localparam int CORDIC_EXTRA = 2;      // angle fold + rounding
	localparam int BOX_STAGES   = 4;      // multiply, abs-sum, bounds, output

	typedef struct packed {
		logic signed [TRIG_W-1:0] cos_v;
		logic signed [TRIG_W-1:0] sin_v;
	} trig_t;

	// round(atan(2^-i) * 2^29)
	function automatic logic [31:0] atan_q29(input int unsigned idx);
		logic [31:0] v;
		case (idx)
			0:       v = 32'd421657428;
			1:       v = 32'd248918915;
			2:       v = 32'd131521918;
			3:       v = 32'd66762579;
			4:       v = 32'd33510843;
			5:       v = 32'd16771758;
			6:       v = 32'd8387925;
			7:       v = 32'd4194219;
			8:       v = 32'd2097141;
			9:       v = 32'd1048575;
			10:      v = 32'd524288;
			11:      v = 32'd262144;
			12:      v = 32'd131072;
			13:      v = 32'd65536;
			14:      v = 32'd32768;
			15:      v = 32'd16384;
			16:      v = 32'd8192;
			17:      v = 32'd4096;
			18:      v = 32'd2048;
			19:      v = 32'd1024;
			20:      v = 32'd512;
			21:      v = 32'd256;
			22:      v = 32'd128;
			23:      v = 32'd64;
			default: v = 32'd0;
		endcase
		return v;
	endfunction

endpackage

// ===== rtl/rotated_rect_bounding_box.sv =====
// Rotated rectangle bounding box, top level: CORDIC pipeline feeding the
// box pipeline. Depends on rrbb_pkg, rrbb_cordic, rrbb_box and the macro header.
//
// Usage:
//   Command channel: present width, height and angle (Q3.13 radians) with
//   start high; the item is taken at any edge where start is high and busy
//   is low. busy is held low, so an item can be issued every cycle.
//   Result channel: done is high for exactly one cycle with top, bottom,
//   left and right valid in that cycle; the receiver cannot stall it.
//   From accept to done an item passes the fold register, the CORDIC stages,
//   the rounding register and the box stages. One CORDIC iteration per stage sets the depth.
//   Throughput: one item per cycle, results in issue order.
//   Reset: arst_n low clears all pipeline valid bits; items in flight are
//   dropped and no done pulse follows until new items are issued.
//   Only the low DIM_BITS bits of width and height take part.
`include "rotated_rect_bounding_box_defines.svh"

module rotated_rect_bounding_box #(
	parameter int DIM_BITS        = rrbb_pkg::DIM_BITS_DEF,
	parameter int TRIG_ITERATIONS = rrbb_pkg::TRIG_ITER_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [rrbb_pkg::IN_W-1:0]          width,
	input  logic [rrbb_pkg::IN_W-1:0]          height,
	input  logic signed [rrbb_pkg::ANG_W-1:0]  angle,
	output logic                               done,
	output logic signed [rrbb_pkg::OUT_W-1:0]  top,
	output logic signed [rrbb_pkg::OUT_W-1:0]  bottom,
	output logic signed [rrbb_pkg::OUT_W-1:0]  left,
	output logic signed [rrbb_pkg::OUT_W-1:0]  right
);
	import rrbb_pkg::*;

	localparam int DW_IN   = (DIM_BITS < IN_W) ? DIM_BITS : IN_W;
	localparam int TAG_W   = 2 * DIM_BITS;
	localparam int LATENCY = TRIG_ITERATIONS + CORDIC_EXTRA + BOX_STAGES;

	logic                accept;
	logic [DIM_BITS-1:0] w_in, h_in;
	logic                trig_vld;
	trig_t               trig;
	logic [TAG_W-1:0]    tag_out;

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign w_in   = DIM_BITS'(width[DW_IN-1:0]);
	assign h_in   = DIM_BITS'(height[DW_IN-1:0]);

	// width and height ride along the CORDIC as a tag
	rrbb_cordic #(
		.TRIG_ITERATIONS (TRIG_ITERATIONS),
		.TAG_W           (TAG_W)
	) u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (accept),
		.angle   (angle),
		.tag_in  ({h_in, w_in}),
		.out_vld (trig_vld),
		.trig    (trig),
		.tag_out (tag_out)
	);

	rrbb_box #(
		.DIM_BITS (DIM_BITS)
	) u_box (
		.clk    (clk),
		.arst_n (arst_n),
		.in_vld (trig_vld),
		.w      (tag_out[DIM_BITS-1:0]),
		.h      (tag_out[TAG_W-1:DIM_BITS]),
		.trig   (trig),
		.done   (done),
		.top    (top),
		.bottom (bottom),
		.left   (left),
		.right  (right)
	);

	`RRBB_ASSERT_IMP(a_done_latency, clk, arst_n, done, $past(start && !busy, LATENCY),
		"done without an item issued LATENCY cycles before")
	`RRBB_ASSERT_ALW(a_x_order, clk, arst_n, !done || (left <= right), "left beyond right")
	`RRBB_ASSERT_ALW(a_y_order, clk, arst_n, !done || (top <= bottom), "top beyond bottom")

endmodule

// ===== rtl/rrbb_cordic.sv =====
// Pipelined rotation-mode CORDIC: quarter-turn fold, one iteration per stage,
// Q1.15 rounding. Depends on rrbb_pkg and the assertion macro header.
`include "rotated_rect_bounding_box_defines.svh"

module rrbb_cordic #(
	parameter int TRIG_ITERATIONS = rrbb_pkg::TRIG_ITER_DEF,
	parameter int TAG_W           = 2 * rrbb_pkg::DIM_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_vld,
	input  logic signed [rrbb_pkg::ANG_W-1:0]  angle,
	input  logic [TAG_W-1:0]                   tag_in,
	output logic                               out_vld,
	output rrbb_pkg::trig_t                    trig,
	output logic [TAG_W-1:0]                   tag_out
);
	import rrbb_pkg::*;

	localparam int N = TRIG_ITERATIONS;
	localparam logic signed [Z_W-1:0] Z_HALF     = Z_W'(HALF_PI_Q29);
	localparam logic signed [Z_W-1:0] Z_NEG_HALF = -Z_W'(HALF_PI_Q29);
	localparam logic signed [Z_W-1:0] Z_PI       = Z_W'(PI_Q29);

	logic signed [Z_W-1:0] z_in;
	logic signed [Z_W-1:0] z_red;
	logic                  neg_red;

	logic signed [XY_W-1:0] x_s   [0:N];
	logic signed [XY_W-1:0] y_s   [0:N];
	logic signed [Z_W-1:0]  z_s   [0:N];
	logic                   neg_s [0:N];
	logic [TAG_W-1:0]       tag_s [0:N];
	logic                   vld_s [0:N];

	trig_t            trig_so;
	logic [TAG_W-1:0] tag_so;
	logic             vld_so;

	// x or -x, plus half an LSB, down to Q1.15 with saturation
	function automatic logic signed [TRIG_W-1:0] to_q15(
		input logic signed [XY_W-1:0] v,
		input logic                   ng
	);
		logic signed [XY_W-1:0]      r;
		logic signed [XY_W-RND_SH-1:0] q;
		logic signed [TRIG_W-1:0]    res;
		r = ng ? (~v + XY_W'(RND_HALF + 1)) : (v + XY_W'(RND_HALF));
		q = r[XY_W-1:RND_SH];
		if (!q[XY_W-RND_SH-1] && (|q[XY_W-RND_SH-2:TRIG_W-1]))
			res = {1'b0, {(TRIG_W-1){1'b1}}};
		else if (q[XY_W-RND_SH-1] && !(&q[XY_W-RND_SH-2:TRIG_W-1]))
			res = {1'b1, {(TRIG_W-1){1'b0}}};
		else
			res = q[TRIG_W-1:0];
		return res;
	endfunction

	// fold the angle into [-pi/2, pi/2]
	always_comb begin
		z_in    = {{(Z_W-ANG_W-ANG_SH){angle[ANG_W-1]}}, angle, {ANG_SH{1'b0}}};
		z_red   = z_in;
		neg_red = 1'b0;
		if (z_in > Z_HALF) begin
			z_red   = z_in - Z_PI;
			neg_red = 1'b1;
		end else if (z_in < Z_NEG_HALF) begin
			z_red   = z_in + Z_PI;
			neg_red = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		x_s[0]   <= XY_W'(GAIN_Q30);
		y_s[0]   <= '0;
		z_s[0]   <= z_red;
		neg_s[0] <= neg_red;
		tag_s[0] <= tag_in;
	end

	for (genvar i = 0; i < N; i++) begin : g_iter
		logic signed [XY_W-1:0] xsh;
		logic signed [XY_W-1:0] ysh;
		logic signed [Z_W-1:0]  atan_v;

		assign xsh    = x_s[i] >>> i;
		assign ysh    = y_s[i] >>> i;
		assign atan_v = Z_W'(atan_q29(i));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (!z_s[i][Z_W-1]) begin
				x_s[i+1] <= x_s[i] - ysh;
				y_s[i+1] <= y_s[i] + xsh;
				z_s[i+1] <= z_s[i] - atan_v;
			end else begin
				x_s[i+1] <= x_s[i] + ysh;
				y_s[i+1] <= y_s[i] - xsh;
				z_s[i+1] <= z_s[i] + atan_v;
			end
			neg_s[i+1] <= neg_s[i];
			tag_s[i+1] <= tag_s[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_so <= 1'b0;
		end else begin
			vld_so <= vld_s[N];
		end
	end

	always_ff @(posedge clk) begin
		trig_so.cos_v <= to_q15(x_s[N], neg_s[N]);
		trig_so.sin_v <= to_q15(y_s[N], neg_s[N]);
		tag_so        <= tag_s[N];
	end

	assign out_vld = vld_so;
	assign trig    = trig_so;
	assign tag_out = tag_so;

	`RRBB_ASSERT_IMP(a_fold_range, clk, arst_n, vld_s[0],
		(z_s[0] <= Z_HALF) && (z_s[0] >= Z_NEG_HALF), "folded angle outside quarter turn")

endmodule

// ===== rtl/rrbb_box.sv =====
// Corner projection and bounding box: four products, abs-sum per axis,
// centre +/- extent, truncate and saturate. Depends on rrbb_pkg.
module rrbb_box #(
	parameter int DIM_BITS = rrbb_pkg::DIM_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_vld,
	input  logic [DIM_BITS-1:0]                w,
	input  logic [DIM_BITS-1:0]                h,
	input  rrbb_pkg::trig_t                    trig,
	output logic                               done,
	output logic signed [rrbb_pkg::OUT_W-1:0]  top,
	output logic signed [rrbb_pkg::OUT_W-1:0]  bottom,
	output logic signed [rrbb_pkg::OUT_W-1:0]  left,
	output logic signed [rrbb_pkg::OUT_W-1:0]  right
);
	import rrbb_pkg::*;

	localparam int PW = DIM_BITS + TRIG_W + 1;           // signed product
	localparam int SW = PW + 1;                          // unsigned extent
	localparam int CW = DIM_BITS + CENTER_SH;            // unsigned centre
	localparam int BW = (DIM_BITS + 19 > OUT_W + TRUNC_SH + 1) ?
		DIM_BITS + 19 : OUT_W + TRUNC_SH + 1;
	localparam int QW = BW - TRUNC_SH;

	logic signed [PW-1:0] w_e, h_e, c_e, s_e;

	logic                 vld_s1;
	logic signed [PW-1:0] wc_s1, hs_s1, ws_s1, hc_s1;
	logic [DIM_BITS-1:0]  w_s1, h_s1;

	logic [PW-1:0]        wc_abs, hs_abs, ws_abs, hc_abs;
	logic                 vld_s2;
	logic [SW-1:0]        ex_s2, ey_s2;
	logic [CW-1:0]        cx_s2, cy_s2;

	logic                 vld_s3;
	logic signed [BW-1:0] xmin_s3, xmax_s3, ymin_s3, ymax_s3;

	logic                    vld_s4;
	logic signed [OUT_W-1:0] top_s4, bottom_s4, left_s4, right_s4;

	// divide by 2^16 toward zero, then clamp to the output range
	function automatic logic signed [OUT_W-1:0] trunc_sat(input logic signed [BW-1:0] v);
		logic signed [BW-1:0]    adj;
		logic signed [QW-1:0]    q;
		logic signed [OUT_W-1:0] res;
		adj = v[BW-1] ? (v + BW'(TRUNC_BIAS)) : v;
		q   = adj[BW-1:TRUNC_SH];
		if (!q[QW-1] && (|q[QW-2:OUT_W-1]))
			res = {1'b0, {(OUT_W-1){1'b1}}};
		else if (q[QW-1] && !(&q[QW-2:OUT_W-1]))
			res = {1'b1, {(OUT_W-1){1'b0}}};
		else
			res = q[OUT_W-1:0];
		return res;
	endfunction

	assign w_e = PW'(w);
	assign h_e = PW'(h);
	assign c_e = PW'(trig.cos_v);
	assign s_e = PW'(trig.sin_v);

	// the bounds are centre +/- (|a| + |b|) per axis
	assign wc_abs = wc_s1[PW-1] ? PW'(-wc_s1) : PW'(wc_s1);
	assign hs_abs = hs_s1[PW-1] ? PW'(-hs_s1) : PW'(hs_s1);
	assign ws_abs = ws_s1[PW-1] ? PW'(-ws_s1) : PW'(ws_s1);
	assign hc_abs = hc_s1[PW-1] ? PW'(-hc_s1) : PW'(hc_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		wc_s1 <= w_e * c_e;
		hs_s1 <= h_e * s_e;
		ws_s1 <= w_e * s_e;
		hc_s1 <= h_e * c_e;
		w_s1  <= w;
		h_s1  <= h;

		ex_s2 <= SW'(wc_abs) + SW'(hs_abs);
		ey_s2 <= SW'(ws_abs) + SW'(hc_abs);
		cx_s2 <= {w_s1, {CENTER_SH{1'b0}}};
		cy_s2 <= {h_s1, {CENTER_SH{1'b0}}};

		xmin_s3 <= BW'(cx_s2) - BW'(ex_s2);
		xmax_s3 <= BW'(cx_s2) + BW'(ex_s2);
		ymin_s3 <= BW'(cy_s2) - BW'(ey_s2);
		ymax_s3 <= BW'(cy_s2) + BW'(ey_s2);

		top_s4    <= trunc_sat(ymin_s3);
		bottom_s4 <= trunc_sat(ymax_s3);
		left_s4   <= trunc_sat(xmin_s3);
		right_s4  <= trunc_sat(xmax_s3);
	end

	assign done   = vld_s4;
	assign top    = top_s4;
	assign bottom = bottom_s4;
	assign left   = left_s4;
	assign right  = right_s4;

endmodule

// ===== bench/tb_rotated_rect_bounding_box.sv =====
// Self-checking bench for rotated_rect_bounding_box: a directed table, then random items,
// each result checked against an in-bench CORDIC and bounding-box predictor or a fixed row.
// Depends on rrbb_pkg (port widths) and the RTL top level.
`timescale 1ns / 100ps

module tb_rotated_rect_bounding_box;

	localparam int     TRIG_ITER    = 16;
	localparam int     RANDOM_ITEMS = 1950;
	localparam int     STALL_LIMIT  = 2000;
	localparam int     TAIL_CYCLES  = 40;      // pipeline depth is 22 at the default size
	localparam int     DIM_W        = rrbb_pkg::IN_W;
	localparam int     ANG_BITS     = rrbb_pkg::ANG_W;
	localparam longint CORDIC_GAIN  = 64'sd652032874;
	localparam longint HALF_TURN    = 64'sd1686629713;
	localparam longint QUARTER_TURN = 64'sd843314857;

	typedef struct packed {
		logic signed [rrbb_pkg::OUT_W-1:0] top;
		logic signed [rrbb_pkg::OUT_W-1:0] bottom;
		logic signed [rrbb_pkg::OUT_W-1:0] left;
		logic signed [rrbb_pkg::OUT_W-1:0] right;
	} box_t;

	typedef struct packed {
		logic [rrbb_pkg::IN_W-1:0]         w;
		logic [rrbb_pkg::IN_W-1:0]         h;
		logic signed [rrbb_pkg::ANG_W-1:0] a;
		bit                                known;
		box_t                              box;
	} rect_item_t;

	logic                               clk = 1'b0;
	logic                               arst_n = 1'b0;
	logic                               start = 1'b0;
	logic                               busy;
	logic [rrbb_pkg::IN_W-1:0]          width = '0;
	logic [rrbb_pkg::IN_W-1:0]          height = '0;
	logic signed [rrbb_pkg::ANG_W-1:0]  angle = '0;
	logic                               done;
	logic signed [rrbb_pkg::OUT_W-1:0]  top;
	logic signed [rrbb_pkg::OUT_W-1:0]  bottom;
	logic signed [rrbb_pkg::OUT_W-1:0]  left;
	logic signed [rrbb_pkg::OUT_W-1:0]  right;

	rect_item_t pending_boxes [$];
	int         errs = 0;
	int         idle_pct = 28;
	int         quiet_cycles = 0;

	// round(atan(2^-i) * 2^29)
	longint atan_tab [0:TRIG_ITER-1] = '{
		64'sd421657428, 64'sd248918915, 64'sd131521918, 64'sd66762579,
		64'sd33510843, 64'sd16771758, 64'sd8387925, 64'sd4194219,
		64'sd2097141, 64'sd1048575, 64'sd524288, 64'sd262144,
		64'sd131072, 64'sd65536, 64'sd32768, 64'sd16384
	};

	// known expectations only where the box collapses to the origin
	rect_item_t dir_rows [0:21] = '{
		'{13'd0,    13'd0,    16'sd0,      1'b1, 60'd0},
		'{13'd0,    13'd0,    16'sd32767,  1'b1, 60'd0},
		'{13'd0,    13'd0,    16'h8000,    1'b1, 60'd0},
		'{13'd8191, 13'd8191, 16'sd0,      1'b0, 60'd0},
		'{13'd8191, 13'd8191, 16'sd32767,  1'b0, 60'd0},
		'{13'd8191, 13'd8191, 16'h8000,    1'b0, 60'd0},
		'{13'd8191, 13'd0,    16'sd6434,   1'b0, 60'd0},
		'{13'd0,    13'd8191, -16'sd6434,  1'b0, 60'd0},
		'{13'd1,    13'd1,    16'sd0,      1'b0, 60'd0},
		'{13'd100,  13'd50,   16'sd12867,  1'b0, 60'd0},
		'{13'd100,  13'd50,   16'sd12868,  1'b0, 60'd0},
		'{13'd100,  13'd50,   -16'sd12867, 1'b0, 60'd0},
		'{13'd100,  13'd50,   -16'sd12868, 1'b0, 60'd0},
		'{13'd640,  13'd480,  16'sd25736,  1'b0, 60'd0},
		'{13'd640,  13'd480,  -16'sd25736, 1'b0, 60'd0},
		'{13'd8191, 13'd1,    16'sd4096,   1'b0, 60'd0},
		'{13'd1,    13'd8191, -16'sd4096,  1'b0, 60'd0},
		'{13'd4095, 13'd2730, 16'sd21000,  1'b0, 60'd0},
		'{13'd5461, 13'd4096, -16'sd30000, 1'b0, 60'd0},
		'{13'd8191, 13'd8191, 16'sd12867,  1'b0, 60'd0},
		'{13'd8191, 13'd8191, -16'sd12867, 1'b0, 60'd0},
		'{13'd3,    13'd7,    16'sd1,      1'b0, 60'd0}
	};

	rotated_rect_bounding_box uut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.width  (width),
		.height (height),
		.angle  (angle),
		.done   (done),
		.top    (top),
		.bottom (bottom),
		.left   (left),
		.right  (right)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Q2.30 -> Q1.15 with round half up, saturated
	function automatic longint q15_round(input longint v);
		longint r;
		r = (v + 64'sd16384) >>> 15;
		if (r > 32767)
			r = 32767;
		else if (r < -32768)
			r = -32768;
		return r;
	endfunction

	// 2^-16 pixel units -> integer pixel, toward zero, saturated to 15 bits
	function automatic logic signed [rrbb_pkg::OUT_W-1:0] clamp_bound(input longint v);
		longint q;
		q = v / 64'sd65536;
		if (q > 16383)
			q = 16383;
		else if (q < -16384)
			q = -16384;
		return q[rrbb_pkg::OUT_W-1:0];
	endfunction

	function automatic box_t predict_box(input logic [rrbb_pkg::IN_W-1:0] w_in,
			input logic [rrbb_pkg::IN_W-1:0] h_in,
			input logic signed [rrbb_pkg::ANG_W-1:0] a_in);
		longint z, x, y, xt, yt, c, s, w, h, dx, dy, px, py;
		longint xmin, xmax, ymin, ymax;
		bit     flip;
		box_t   b;
		w = w_in;
		h = h_in;
		z = longint'(a_in) * 64'sd65536;
		x = CORDIC_GAIN;
		y = 0;
		flip = 1'b0;
		// fold into +-pi/2, undo by negating the result
		if (z > QUARTER_TURN) begin
			z = z - HALF_TURN;
			flip = 1'b1;
		end else if (z < -QUARTER_TURN) begin
			z = z + HALF_TURN;
			flip = 1'b1;
		end
		for (int i = 0; i < TRIG_ITER; i++) begin
			xt = x >>> i;
			yt = y >>> i;
			if (z >= 0) begin
				x = x - yt;
				y = y + xt;
				z = z - atan_tab[i];
			end else begin
				x = x + yt;
				y = y - xt;
				z = z + atan_tab[i];
			end
		end
		if (flip) begin
			x = -x;
			y = -y;
		end
		c = q15_round(x);
		s = q15_round(y);
		xmin = 0; xmax = 0; ymin = 0; ymax = 0;
		// corners relative to the centre in half-pixel units
		for (int k = 0; k < 4; k++) begin
			dx = k[0] ? w : -w;
			dy = k[1] ? h : -h;
			px = dx * c + dy * s + w * 64'sd32768;
			py = -dx * s + dy * c + h * 64'sd32768;
			if (k == 0 || px < xmin) xmin = px;
			if (k == 0 || px > xmax) xmax = px;
			if (k == 0 || py < ymin) ymin = py;
			if (k == 0 || py > ymax) ymax = py;
		end
		b.top    = clamp_bound(ymin);
		b.bottom = clamp_bound(ymax);
		b.left   = clamp_bound(xmin);
		b.right  = clamp_bound(xmax);
		return b;
	endfunction

	// entered just after a falling edge, leaves just after a falling edge once its item is taken
	task automatic send_rect(input logic [rrbb_pkg::IN_W-1:0] w,
			input logic [rrbb_pkg::IN_W-1:0] h,
			input logic signed [rrbb_pkg::ANG_W-1:0] a,
			input bit known, input box_t fixed);
		rect_item_t p;
		while ($urandom_range(99, 0) < idle_pct) begin
			start = 1'b0;
			@(negedge clk);
		end
		start = 1'b1;
		width = w;
		height = h;
		angle = a;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		p.w = w;
		p.h = h;
		p.a = a;
		p.known = known;
		p.box = known ? fixed : predict_box(w, h, a);
		pending_boxes.push_back(p);
		@(negedge clk);
	endtask

	always @(posedge clk) begin : box_check
		rect_item_t p;
		if (arst_n && done !== 1'b0) begin
			if (pending_boxes.size() == 0) begin
				errs++;
				$display("%0t: unexpected result t/b/l/r=%0d/%0d/%0d/%0d",
					$time, top, bottom, left, right);
			end else begin
				p = pending_boxes.pop_front();
				if (top !== p.box.top || bottom !== p.box.bottom ||
						left !== p.box.left || right !== p.box.right) begin
					errs++;
					$display("%0t: w=%0d h=%0d a=%0d exp t/b/l/r=%0d/%0d/%0d/%0d",
						$time, p.w, p.h, p.a, p.box.top, p.box.bottom,
						p.box.left, p.box.right);
					$display("%0t:   got t/b/l/r=%0d/%0d/%0d/%0d",
						$time, top, bottom, left, right);
				end
			end
		end
	end

	// nothing accepted and nothing returned for too long
	always @(posedge clk) begin
		if ((start && !busy) || done)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		int                                sel;
		int                                ai;
		logic [rrbb_pkg::IN_W-1:0]         w;
		logic [rrbb_pkg::IN_W-1:0]         h;
		logic signed [rrbb_pkg::ANG_W-1:0] a;
		box_t                              none;
		none = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (dir_rows[r])
			send_rect(dir_rows[r].w, dir_rows[r].h, dir_rows[r].a, dir_rows[r].known,
				dir_rows[r].box);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			idle_pct = (n >= 600 && n < 1000) ? 0 : 28;
			w = DIM_W'($urandom_range(8191, 0));
			h = DIM_W'($urandom_range(8191, 0));
			a = ANG_BITS'($urandom_range(65535, 0));
			sel = $urandom_range(99, 0);
			if (sel >= 45 && sel < 65) begin
				w = DIM_W'($urandom_range(63, 0));
				h = DIM_W'($urandom_range(63, 0));
			end else if (sel >= 65 && sel < 80) begin
				// around zero, the quarter-turn folds and half a turn
				case ($urandom_range(4, 0))
					0: ai = 0;
					1: ai = 12868;
					2: ai = -12868;
					3: ai = 25736;
					default: ai = -25736;
				endcase
				ai = ai + int'($urandom_range(6, 0)) - 3;
				a = ai[rrbb_pkg::ANG_W-1:0];
			end else if (sel >= 80 && sel < 90) begin
				if ($urandom_range(1, 0))
					w = '0;
				else
					h = '0;
			end else if (sel >= 90) begin
				case ($urandom_range(2, 0))
					0: w = '0;
					1: w = '1;
					default: ;
				endcase
				case ($urandom_range(2, 0))
					0: h = '0;
					1: h = '1;
					default: ;
				endcase
				case ($urandom_range(2, 0))
					0: a = 16'sd32767;
					1: a = 16'h8000;
					default: a = '0;
				endcase
			end
			send_rect(w, h, a, 1'b0, none);
		end
		start = 1'b0;

		while (pending_boxes.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errs == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/rrbb_pkg.sv
rtl/rrbb_cordic.sv
rtl/rrbb_box.sv
rtl/rotated_rect_bounding_box.sv
bench/tb_rotated_rect_bounding_box.sv
